>>> sv/lgrs_pkg.sv
package lgrs_pkg;

  localparam int COLS        = 64;
  localparam int WIDTH_BITS  = 7;
  localparam int COUNT_BITS  = 7;
  localparam int BIRTH_COUNT = 3;
  localparam int STAY_COUNT  = 2;

  typedef logic [COLS-1:0]       row_t;
  typedef logic [WIDTH_BITS-1:0] width_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  typedef struct packed {
    row_t up;
    row_t mid;
    row_t down;
    logic done;
  } job_t;

  typedef struct packed {
    row_t next;
    row_t born;
    row_t died;
    logic done;
  } lane_t;

  function automatic row_t width_mask(width_t w);
    row_t m;
    if (w == '0) begin
      m = row_t'(1);
    end else if (w >= WIDTH_BITS'(COLS)) begin
      m = '1;
    end else begin
      m = (row_t'(1) << w) - row_t'(1);
    end
    return m;
  endfunction

  function automatic count_t popcount(row_t r);
    logic [1:0] l1 [COLS/2];
    logic [2:0] l2 [COLS/4];
    logic [3:0] l3 [COLS/8];
    logic [4:0] l4 [COLS/16];
    logic [5:0] l5 [COLS/32];
    for (int i = 0; i < COLS/2; i++) begin
      l1[i] = {1'b0, r[2*i]} + {1'b0, r[2*i+1]};
    end
    for (int i = 0; i < COLS/4; i++) begin
      l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
    end
    for (int i = 0; i < COLS/8; i++) begin
      l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
    end
    for (int i = 0; i < COLS/16; i++) begin
      l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
    end
    for (int i = 0; i < COLS/32; i++) begin
      l5[i] = {1'b0, l4[2*i]} + {1'b0, l4[2*i+1]};
    end
    return count_t'({1'b0, l5[0]} + {1'b0, l5[1]});
  endfunction

endpackage

>>> sv/lgrs_ifs.sv
interface lgrs_row_if;
  logic               valid;
  logic               ready;
  lgrs_pkg::row_t     row_cells;
  logic               is_last_row;
  modport source (output valid, output row_cells, output is_last_row, input ready);
  modport sink (input valid, input row_cells, input is_last_row, output ready);
endinterface

interface lgrs_res_if;
  logic               valid;
  logic               ready;
  lgrs_pkg::row_t     next_row_cells;
  lgrs_pkg::count_t   births;
  lgrs_pkg::count_t   deaths;
  logic               board_done;
  modport source (output valid, output next_row_cells, output births, output deaths,
                  output board_done, input ready);
  modport sink (input valid, input next_row_cells, input births, input deaths,
                input board_done, output ready);
endinterface

interface lgrs_cfg_if;
  logic               valid;
  logic               ready;
  lgrs_pkg::width_t   width_in_use;
  modport source (output valid, output width_in_use, input ready);
  modport sink (input valid, input width_in_use, output ready);
endinterface

>>> sv/life_generation_row_stream.sv
// Each result is registered in the lane stage and then in the merge output register.
// Throughput: one row per cycle while the output is not stalled; a bottom row that
// follows a held row yields two results and blocks the input while the second is issued.
// One lane per column evaluates the 3x3 neighborhood; a merge stage counts births/deaths.
// Reset (synchronous, rst high): held rows cleared, pipeline emptied, width back to 64.
module life_generation_row_stream (
  input  logic         clk,
  input  logic         rst,
  lgrs_cfg_if.sink     cfg,
  lgrs_row_if.sink     rows,
  lgrs_res_if.source   results
);

  lgrs_pkg::row_t   col_mask;
  lgrs_pkg::row_t   above;
  lgrs_pkg::row_t   middle;
  logic             mid_valid;
  logic             pend_valid;
  lgrs_pkg::row_t   pend_up;
  lgrs_pkg::row_t   pend_mid;

  lgrs_pkg::row_t   cur;
  lgrs_pkg::job_t   job;
  logic             job_valid;
  logic             accept;

  logic             lane_valid;
  lgrs_pkg::lane_t  lane;
  logic             lane_ready;
  logic             merge_ready;

  lgrs_pkg::row_t   up_m;
  lgrs_pkg::row_t   mid_m;
  lgrs_pkg::row_t   down_m;
  logic [lgrs_pkg::COLS+1:0] up_p;
  logic [lgrs_pkg::COLS+1:0] mid_p;
  logic [lgrs_pkg::COLS+1:0] down_p;
  lgrs_pkg::row_t   next_raw;
  lgrs_pkg::row_t   next_m;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_mask <= '1;
    end else if (cfg.valid) begin
      col_mask <= lgrs_pkg::width_mask(cfg.width_in_use);
    end
  end

  assign cur        = rows.row_cells & col_mask;
  assign lane_ready = !lane_valid || merge_ready;
  assign rows.ready = !pend_valid && lane_ready;
  assign accept     = rows.valid && rows.ready;

  always_comb begin
    if (pend_valid) begin
      job       = '{up: pend_up, mid: pend_mid, down: '0, done: 1'b1};
      job_valid = 1'b1;
    end else if (mid_valid) begin
      job       = '{up: above, mid: middle, down: cur, done: 1'b0};
      job_valid = rows.valid;
    end else begin
      job       = '{up: '0, mid: cur, down: '0, done: 1'b1};
      job_valid = rows.valid && rows.is_last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      above      <= '0;
      middle     <= '0;
      mid_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (accept) begin
      if (rows.is_last_row) begin
        above      <= '0;
        middle     <= '0;
        mid_valid  <= 1'b0;
        pend_valid <= mid_valid;
      end else begin
        above     <= mid_valid ? middle : '0;
        middle    <= cur;
        mid_valid <= 1'b1;
      end
    end else if (pend_valid && lane_ready) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && rows.is_last_row) begin
      pend_up  <= middle;
      pend_mid <= cur;
    end
  end

  assign up_m   = job.up & col_mask;
  assign mid_m  = job.mid & col_mask;
  assign down_m = job.down & col_mask;
  assign up_p   = {1'b0, up_m, 1'b0};
  assign mid_p  = {1'b0, mid_m, 1'b0};
  assign down_p = {1'b0, down_m, 1'b0};

  for (genvar c = 0; c < lgrs_pkg::COLS; c++) begin : g_lane
    lgrs_cell u_cell (
      .up   (up_p[c+2:c]),
      .mid  (mid_p[c+2:c]),
      .down (down_p[c+2:c]),
      .next (next_raw[c])
    );
  end

  assign next_m = next_raw & col_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_valid <= 1'b0;
    end else if (lane_ready) begin
      lane_valid <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (lane_ready && job_valid) begin
      lane <= '{next: next_m, born: next_m & ~mid_m, died: mid_m & ~next_m, done: job.done};
    end
  end

  lgrs_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .lane_valid (lane_valid),
    .lane       (lane),
    .lane_ready (merge_ready),
    .res        (results)
  );

endmodule

>>> sv/lgrs_cell.sv
module lgrs_cell (
  input  logic [2:0] up,
  input  logic [2:0] mid,
  input  logic [2:0] down,
  output logic       next
);

  logic [3:0] n;

  always_comb begin
    n = 4'(up[0]) + 4'(up[1]) + 4'(up[2]) + 4'(mid[0]) + 4'(mid[2])
      + 4'(down[0]) + 4'(down[1]) + 4'(down[2]);
    if (mid[1]) begin
      next = (n == 4'(lgrs_pkg::STAY_COUNT)) || (n == 4'(lgrs_pkg::BIRTH_COUNT));
    end else begin
      next = (n == 4'(lgrs_pkg::BIRTH_COUNT));
    end
  end

endmodule

>>> sv/lgrs_merge.sv
module lgrs_merge (
  input  logic                clk,
  input  logic                rst,
  input  logic                lane_valid,
  input  lgrs_pkg::lane_t     lane,
  output logic                lane_ready,
  lgrs_res_if.source          res
);

  logic              out_valid;
  lgrs_pkg::row_t    out_row;
  lgrs_pkg::count_t  out_births;
  lgrs_pkg::count_t  out_deaths;
  logic              out_done;

  assign lane_ready = !out_valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (lane_ready) begin
      out_valid <= lane_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (lane_ready && lane_valid) begin
      out_row    <= lane.next;
      out_births <= lgrs_pkg::popcount(lane.born);
      out_deaths <= lgrs_pkg::popcount(lane.died);
      out_done   <= lane.done;
    end
  end

  assign res.valid          = out_valid;
  assign res.next_row_cells = out_row;
  assign res.births         = out_births;
  assign res.deaths         = out_deaths;
  assign res.board_done     = out_done;

endmodule

>>> sv/lgrs_checker.sv
module lgrs_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   res_valid,
  input logic                   res_ready,
  input lgrs_pkg::row_t         next_row_cells,
  input lgrs_pkg::count_t       births,
  input lgrs_pkg::count_t       deaths
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(next_row_cells) && $stable(births))
    else $error("stalled result item changed");

  a_count_sum: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ({1'b0, births} + {1'b0, deaths}) <= 8'(lgrs_pkg::COLS))
    else $error("births plus deaths exceed row width");

  a_births_live: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> 32'(births) <= 32'($countones(next_row_cells)))
    else $error("births exceed live cells of result row");

endmodule

bind life_generation_row_stream lgrs_checker u_lgrs_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (results.valid),
  .res_ready      (results.ready),
  .next_row_cells (results.next_row_cells),
  .births         (results.births),
  .deaths         (results.deaths)
);
